FILE: rtl/core/tclcd_pkg.sv
// ----------------------------------------------------------------------------
// tclcd_pkg
// Shared types and constants for the character display nibble writer.
// ----------------------------------------------------------------------------
package tclcd_pkg;

	localparam int IDX_W  = 3;  // configuration register index width
	localparam int DATA_W = 7;  // widest configuration register
	localparam int LEN_W  = 5;  // line_length width
	localparam int ADDR_W = 7;  // display address width
	localparam int COL_W  = 7;  // column count width
	localparam int LINE_W = 2;  // line number width
	localparam int CHAR_W = 8;
	localparam int NIB_W  = 4;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_LINE_LENGTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_LINE_START_0 = 3'd1;
	localparam logic [IDX_W-1:0] REG_LINE_START_1 = 3'd2;
	localparam logic [IDX_W-1:0] REG_LINE_START_2 = 3'd3;
	localparam logic [IDX_W-1:0] REG_LINE_START_3 = 3'd4;

	// register reset values
	localparam logic [LEN_W-1:0]  LINE_LENGTH_RST  = 5'd20;
	localparam logic [ADDR_W-1:0] LINE_START_0_RST = 7'h00;
	localparam logic [ADDR_W-1:0] LINE_START_1_RST = 7'h40;
	localparam logic [ADDR_W-1:0] LINE_START_2_RST = 7'h14;
	localparam logic [ADDR_W-1:0] LINE_START_3_RST = 7'h54;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
	localparam logic [COL_W-1:0]  COLUMN_MAX   = 7'd127;

	// register-select values
	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_PAD_HI  = 7'b0000010,
		ST_PAD_LO  = 7'b0000100,
		ST_ADDR_HI = 7'b0001000,
		ST_ADDR_LO = 7'b0010000,
		ST_CHAR_HI = 7'b0100000,
		ST_CHAR_LO = 7'b1000000
	} state_t;

endpackage

FILE: rtl/core/text_to_char_lcd_nibbles.sv
// ----------------------------------------------------------------------------
// text_to_char_lcd_nibbles
// Turns a stream of characters into 4-bit register writes for a character
// display: data bytes for text, space padding and a set-address command on
// newline, every byte sent high nibble first.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  input    | in        | in_valid / in_ready  | character[7:0]
//  output   | out       | out_valid / out_ready| reg_select, nibble[3:0], last
//  config   | in        | wr_en (no wait)      | wr_index[2:0], wr_data[6:0]
//
//  Sequence: an ordinary character is accepted, then sent as two nibbles. A
//  newline is followed by P spaces of padding (0..31), then the set-address
//  command. One nibble leaves per cycle while out_ready is high; the
//  sequencer and its column compare unit set that pace. in_ready is high only
//  while the sequencer is idle. Reset: arst_n clears state, line/column
//  counters and out_valid, and loads the register reset values. No clearing pass.
//  Stalls: out_ready low holds the output register; the sequencer waits.
//
module text_to_char_lcd_nibbles #(
	parameter int LINE_COUNT = 4  // display lines, 1..4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           wr_en,
	input  logic [tclcd_pkg::IDX_W-1:0]    wr_index,
	input  logic [tclcd_pkg::DATA_W-1:0]   wr_data,
	// character input
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [tclcd_pkg::CHAR_W-1:0]   character,
	// nibble output
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           reg_select,
	output logic [tclcd_pkg::NIB_W-1:0]    nibble,
	output logic                           last
);
	import tclcd_pkg::*;

	// configuration registers
	logic [LEN_W-1:0]  line_length_q;
	logic [ADDR_W-1:0] line_start_q [4];

	// sequencer state
	state_t             state_q;
	logic [CHAR_W-1:0]  char_q;
	logic [COL_W-1:0]   column_count_q;
	logic [LINE_W-1:0]  current_line_q;

	// output register
	logic               out_valid_q;
	logic               rs_q;
	logic [NIB_W-1:0]   nib_q;
	logic               last_q;

	// nibble offered by the sequencer this cycle
	logic               emit_valid;
	logic               emit_rs;
	logic [NIB_W-1:0]   emit_nib;
	logic               emit_last;
	logic               fire;

	// shared column compare unit
	logic [COL_W-1:0]   pad_col;
	logic               more_pad;

	// line advance
	logic [LINE_W:0]    line_sum;
	logic [LINE_W-1:0]  next_line;
	logic [ADDR_W-1:0]  cur_start;

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign reg_select = rs_q;
	assign nibble     = nib_q;
	assign last       = last_q;

	// The one compare unit serves both the newline start (current column)
	// and each padding step (column after this space).
	assign pad_col  = (state_q == ST_PAD_LO) ? COL_W'(column_count_q + 7'd1) : column_count_q;
	assign more_pad = (pad_col < {2'b00, line_length_q});

	assign line_sum  = {1'b0, current_line_q} + 3'd1;
	assign next_line = (line_sum >= (LINE_W+1)'(LINE_COUNT)) ? '0 : line_sum[LINE_W-1:0];
	assign cur_start = line_start_q[current_line_q];

	// nibble selection per state
	always_comb begin
		emit_valid = 1'b1;
		emit_rs    = RS_DATA;
		emit_nib   = '0;
		emit_last  = 1'b0;
		case (state_q)
			ST_PAD_HI:  emit_nib = SPACE_CODE[7:4];
			ST_PAD_LO:  emit_nib = SPACE_CODE[3:0];
			ST_ADDR_HI: begin
				emit_rs  = RS_CMD;
				emit_nib = {1'b1, cur_start[6:4]};  // 128 + address
			end
			ST_ADDR_LO: begin
				emit_rs   = RS_CMD;
				emit_nib  = cur_start[3:0];
				emit_last = 1'b1;
			end
			ST_CHAR_HI: emit_nib = char_q[7:4];
			ST_CHAR_LO: begin
				emit_nib  = char_q[3:0];
				emit_last = 1'b1;
			end
			default:    emit_valid = 1'b0;
		endcase
	end

	assign fire = emit_valid && (!out_valid_q || out_ready);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q   <= LINE_LENGTH_RST;
			line_start_q[0] <= LINE_START_0_RST;
			line_start_q[1] <= LINE_START_1_RST;
			line_start_q[2] <= LINE_START_2_RST;
			line_start_q[3] <= LINE_START_3_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_LINE_LENGTH:  line_length_q   <= wr_data[LEN_W-1:0];
				REG_LINE_START_0: line_start_q[0] <= wr_data;
				REG_LINE_START_1: line_start_q[1] <= wr_data;
				REG_LINE_START_2: line_start_q[2] <= wr_data;
				REG_LINE_START_3: line_start_q[3] <= wr_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			column_count_q <= '0;
			current_line_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (character == NEWLINE_CODE) begin
							if (more_pad) begin
								state_q <= ST_PAD_HI;
							end else begin
								current_line_q <= next_line;
								column_count_q <= '0;
								state_q        <= ST_ADDR_HI;
							end
						end else begin
							state_q <= ST_CHAR_HI;
						end
					end
				end
				ST_PAD_HI: if (fire) state_q <= ST_PAD_LO;
				ST_PAD_LO: begin
					if (fire) begin
						if (more_pad) begin
							column_count_q <= pad_col;
							state_q        <= ST_PAD_HI;
						end else begin
							current_line_q <= next_line;
							column_count_q <= '0;
							state_q        <= ST_ADDR_HI;
						end
					end
				end
				ST_ADDR_HI: if (fire) state_q <= ST_ADDR_LO;
				ST_ADDR_LO: if (fire) state_q <= ST_IDLE;
				ST_CHAR_HI: if (fire) state_q <= ST_CHAR_LO;
				ST_CHAR_LO: begin
					if (fire) begin
						if (column_count_q < COLUMN_MAX) begin
							column_count_q <= column_count_q + 7'd1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// character hold register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_q <= character;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rs_q   <= emit_rs;
			nib_q  <= emit_nib;
			last_q <= emit_last;
		end
	end

	// checks
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_pad_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAD_HI || state_q == ST_PAD_LO) |->
			(column_count_q < {2'b00, line_length_q}))
		else $error("padding past line length");

	a_addr_col_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADDR_HI || state_q == ST_ADDR_LO) |-> (column_count_q == '0))
		else $error("column not cleared before address command");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready right after accepting a character");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && emit_last) |=> (state_q == ST_IDLE))
		else $error("last nibble did not end the transaction");

endmodule
